>>> design/assert_macros.svh
// Assertion macros used by the port-level checker of the display block.
// Depends on nothing; the using module provides aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset
`define SSSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sssd assertion failed");

// Next-cycle implication, masked during reset
`define SSSD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sssd assertion failed");

// Next-cycle implication that also holds across reset
`define SSSD_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("sssd reset assertion failed");

`endif

>>> design/sssd_pkg.sv
// Package for the seven-segment display driver: action codes, digit types,
// segment lookup and byte-to-BCD conversion. No dependencies.
package sssd_pkg;

    localparam int NUM_DIGITS = 4;

    typedef logic [3:0] digit_t;
    typedef digit_t [NUM_DIGITS-1:0] digits_t;

    // Action codes carried on the input channel
    localparam logic [1:0] ACT_SCAN  = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_COUNT = 2'd2;

    localparam logic [7:0] SEG_POINT = 8'h80;
    localparam logic [1:0] POINT_POS = 2'd2;

    // Update commands from the front end to the digit store
    typedef struct packed {
        logic load;
        logic count;
    } sssd_cmd_t;

    // Active-high segments a..g for one digit; codes above 9 are blank
    function automatic logic [7:0] seg_lut(input digit_t d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Shift-and-add-3 conversion of a byte into three BCD digits
    function automatic logic [11:0] bin8_to_bcd(input logic [7:0] v);
        logic [11:0] bcd;
        bcd = 12'd0;
        for (int i = 7; i >= 0; i--) begin
            for (int n = 0; n < 3; n++) begin
                if (bcd[n*4 +: 4] >= 4'd5) begin
                    bcd[n*4 +: 4] = bcd[n*4 +: 4] + 4'd3;
                end
            end
            bcd = {bcd[10:0], v[i]};
        end
        return bcd;
    endfunction

endpackage

>>> design/sssd_digits.sv
// Digit store of the display driver: shown digits, BCD event counter and
// the decimal point flag. Depends on sssd_pkg.
module sssd_digits
    import sssd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  sssd_cmd_t  cmd,
    input  logic [7:0] load_value,
    output digits_t    digits,
    output logic       point_on
);

    digits_t digits_reg, digits_next;
    digits_t count_reg, count_next;
    // Set while the counter holds 10000 (shown as 0000)
    logic    wrap_reg, wrap_next;
    logic    point_reg, point_next;
    logic    carry;
    logic [11:0] load_bcd;

    assign load_bcd = bin8_to_bcd(load_value);

    // BCD increment of the counter, with the 10000 step and return to zero
    always_comb begin
        count_next = count_reg;
        wrap_next  = wrap_reg;
        carry      = 1'b1;
        if (wrap_reg) begin
            count_next = '0;
            wrap_next  = 1'b0;
        end else begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                if (carry) begin
                    if (count_reg[i] == 4'd9) begin
                        count_next[i] = 4'd0;
                    end else begin
                        count_next[i] = count_reg[i] + 4'd1;
                        carry         = 1'b0;
                    end
                end
            end
            wrap_next = carry;
        end
    end

    // Next shown digits and point
    always_comb begin
        digits_next = digits_reg;
        point_next  = point_reg;
        if (cmd.load) begin
            digits_next = {4'd0, load_bcd};
        end else if (cmd.count) begin
            digits_next = count_next;
            point_next  = ~point_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg <= '0;
            count_reg  <= '0;
            wrap_reg   <= 1'b0;
            point_reg  <= 1'b1;
        end else begin
            digits_reg <= digits_next;
            point_reg  <= point_next;
            if (cmd.count) begin
                count_reg <= count_next;
                wrap_reg  <= wrap_next;
            end
        end
    end

    assign digits   = digits_reg;
    assign point_on = point_reg;

endmodule

>>> design/seven_segment_reading_display.sv
// A scan request is accepted into the input register, and its result is loaded
// into the result register once the result slot is free, which raises m_valid.
// Requests move at one per cycle while scans find the result slot free; loads and
// counts leave no result and never wait on the result side.
// Reset (aresetn, synchronous, active low): scan position 0, all digits 0,
// counter 0, point on, both registers empty. Depends on sssd_pkg, sssd_digits.
module seven_segment_reading_display
    import sssd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_reading_low,
    input  logic [7:0] s_reading_high,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_digit_strobe,
    output logic [7:0] m_segments_n
);

    logic       in_valid_reg;
    logic [1:0] action_reg;
    logic [7:0] low_reg;
    logic [7:0] high_reg;

    logic       out_valid_reg, out_valid_next;
    logic [3:0] strobe_reg;
    logic [7:0] seg_n_reg;

    logic [1:0] pos_reg;
    logic       out_free;
    logic       is_scan;
    logic       take;
    logic       scan_take;
    sssd_cmd_t  cmd;
    digits_t    digits;
    logic       point_on;
    logic [7:0] pattern;

    // A scan needs the result slot; other requests pass straight through
    assign out_free  = !out_valid_reg || m_ready;
    assign is_scan   = (action_reg == ACT_SCAN);
    assign take      = in_valid_reg && (!is_scan || out_free);
    assign scan_take = take && is_scan;
    assign s_ready   = !in_valid_reg || take;

    assign cmd.load  = take && (action_reg == ACT_LOAD);
    assign cmd.count = take && (action_reg == ACT_COUNT);

    sssd_digits u_digits (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .load_value ({high_reg[3:0], low_reg[7:4]}),
        .digits     (digits),
        .point_on   (point_on)
    );

    // Segment pattern for the current scan position
    always_comb begin
        pattern = seg_lut(digits[pos_reg]);
        if (pos_reg == POINT_POS && point_on) begin
            pattern = pattern | SEG_POINT;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (scan_take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            action_reg <= s_action;
            low_reg    <= s_reading_low;
            high_reg   <= s_reading_high;
        end
    end

    // Scan position and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (scan_take) begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
        if (scan_take) begin
            strobe_reg <= 4'b1000 >> pos_reg;
            seg_n_reg  <= ~pattern;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_digit_strobe = strobe_reg;
    assign m_segments_n   = seg_n_reg;

endmodule

>>> design/sssd_checker.sv
// Port-level checker for the seven-segment display driver, bound to the top.
// Depends on assert_macros.svh and sssd_pkg.
`include "assert_macros.svh"

module sssd_checker
    import sssd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_digit_strobe,
    input logic [7:0] m_segments_n
);

    // Stalled result stays valid
    `SSSD_ASSERT_NXT(a_valid_hold, m_valid && !m_ready, m_valid)
    // Stalled result keeps its payload
    `SSSD_ASSERT_NXT(a_data_hold, m_valid && !m_ready, $stable({m_digit_strobe, m_segments_n}))
    // Exactly one digit enabled per result
    `SSSD_ASSERT_IMP(a_strobe_onehot, m_valid, $onehot(m_digit_strobe))
    // Point only lit on the third scanned digit
    `SSSD_ASSERT_IMP(a_point_pos, m_valid && m_digit_strobe != 4'b0010, m_segments_n[7])
    // Reset empties the result side
    `SSSD_ASSERT_RST(a_reset_empty, !aresetn, !m_valid)

endmodule

bind seven_segment_reading_display sssd_checker u_sssd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_digit_strobe (m_digit_strobe),
    .m_segments_n   (m_segments_n)
);

>>> tb/sv/seven_segment_reading_display_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the four-digit seven-segment display driver.
// Uses sssd_pkg and seven_segment_reading_display; a local display model predicts every scan.
module seven_segment_reading_display_tb;
    import sssd_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;   // unused action code, ignored by the block
    localparam int COUNT_WRAP = 10000;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 10;

    // Active-high segment font; codes above 9 are blank
    localparam logic [7:0] SEG_FONT [16] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct {
        logic [1:0] action;
        logic [7:0] reading_low;
        logic [7:0] reading_high;
        bit         hold;      // wait until every scan result is back
        int         tx_pct;    // sender idle chance
        int         rx_pct;    // receiver stall chance
    } display_request_t;

    typedef struct {
        logic [3:0] strobe;
        logic [7:0] segments_n;
    } scan_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_action = ACT_SCAN;
    logic [7:0] s_reading_low = '0;
    logic [7:0] s_reading_high = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_digit_strobe;
    logic [7:0] m_segments_n;

    display_request_t pending_requests[$];
    scan_result_t     expected_scans[$];
    int               scans_outstanding = 0;
    int               rx_stall_pct = 61;

    // Generator state
    int gen_tx_pct;
    int gen_rx_pct;
    bit gen_hold = 1'b0;

    // Display model state
    logic [1:0]  model_scan_pos;
    digits_t     model_digits;
    logic        model_point_on;
    logic [13:0] model_count;

    // Statistics
    int fail_count = 0;
    int n_scan = 0, n_load = 0, n_count = 0, n_none = 0;
    int n_checked = 0;
    int quiet_cycles = 0;

    seven_segment_reading_display dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_reading_low  (s_reading_low),
        .s_reading_high (s_reading_high),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digit_strobe (m_digit_strobe),
        .m_segments_n   (m_segments_n)
    );

    always #10 aclk = ~aclk;

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endfunction

    // Split a value into the four decimal digits of the model
    task automatic set_model_digits(input int unsigned v);
        model_digits[0] = digit_t'(v % 10);
        model_digits[1] = digit_t'((v / 10) % 10);
        model_digits[2] = digit_t'((v / 100) % 10);
        model_digits[3] = digit_t'((v / 1000) % 10);
    endtask

    // Advance the display model by one request; a scan yields one result
    task automatic step_display_model(input logic [1:0] act, input logic [7:0] lo,
                                      input logic [7:0] hi, output bit has_scan,
                                      output scan_result_t res);
        logic [7:0]  pattern;
        int unsigned next_count;
        has_scan = 1'b0;
        res = '{default: '0};
        case (act)
            ACT_SCAN: begin
                pattern = SEG_FONT[model_digits[model_scan_pos]];
                if (model_scan_pos == POINT_POS && model_point_on) begin
                    pattern = pattern | SEG_POINT;
                end
                res.strobe = 4'b1000 >> model_scan_pos;
                res.segments_n = ~pattern;
                has_scan = 1'b1;
                model_scan_pos = model_scan_pos + 2'd1;
            end
            ACT_LOAD: begin
                // upper nibble from the high byte, lower from the top of the low byte
                set_model_digits({24'd0, hi[3:0], lo[7:4]});
            end
            ACT_COUNT: begin
                next_count = (model_count >= COUNT_WRAP) ? 0 : model_count + 1;
                model_count = next_count[13:0];
                set_model_digits(next_count);
                model_point_on = ~model_point_on;
            end
            default: begin
            end
        endcase
    endtask

    // Driver: presents queued requests, idles at random, honors hold points
    always @(posedge aclk) begin
        display_request_t nxt;
        bit launch;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            launch = 1'b0;
            if (pending_requests.size() > 0) begin
                nxt = pending_requests[0];
                if ((!nxt.hold || (!s_valid && scans_outstanding == 0)) &&
                    $urandom_range(0, 99) >= nxt.tx_pct) begin
                    launch = 1'b1;
                end
            end
            if (launch) begin
                void'(pending_requests.pop_front());
                s_valid <= 1'b1;
                s_action <= nxt.action;
                s_reading_low <= nxt.reading_low;
                s_reading_high <= nxt.reading_high;
                rx_stall_pct <= nxt.rx_pct;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Monitor: predicts on each accepted request, checks each scan result
    always @(posedge aclk) begin
        bit           has_scan;
        scan_result_t res;
        scan_result_t want;
        if (!aresetn) begin
            model_scan_pos = 2'd0;
            model_digits = '0;
            model_point_on = 1'b1;
            model_count = '0;
        end else begin
            if (s_valid && s_ready) begin
                case (s_action)
                    ACT_SCAN:  n_scan++;
                    ACT_LOAD:  n_load++;
                    ACT_COUNT: n_count++;
                    default:   n_none++;
                endcase
                step_display_model(s_action, s_reading_low, s_reading_high, has_scan, res);
                if (has_scan) begin
                    expected_scans.push_back(res);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_scans.size() == 0) begin
                    note_failure($sformatf("unexpected result strobe=%h segments_n=%h",
                                           m_digit_strobe, m_segments_n));
                end else begin
                    want = expected_scans.pop_front();
                    n_checked++;
                    if (m_digit_strobe !== want.strobe || m_segments_n !== want.segments_n) begin
                        note_failure($sformatf(
                            "scan %0d: strobe exp %h got %h, segments_n exp %h got %h",
                            n_checked, want.strobe, m_digit_strobe,
                            want.segments_n, m_segments_n));
                    end
                end
            end
            // watchdog on handshake progress
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
            scans_outstanding <= expected_scans.size();
        end
    end

    task automatic queue_request(input logic [1:0] act, input logic [7:0] lo,
                                 input logic [7:0] hi);
        display_request_t r;
        r.action = act;
        r.reading_low = lo;
        r.reading_high = hi;
        r.hold = gen_hold;
        r.tx_pct = gen_tx_pct;
        r.rx_pct = gen_rx_pct;
        gen_hold = 1'b0;
        pending_requests.push_back(r);
    endtask

    // A run of n scan requests, with random don't-care bytes
    task automatic queue_scans(input int n);
        for (int i = 0; i < n; i++) begin
            queue_request(ACT_SCAN, 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic queue_random(input int n);
        int pick;
        logic [1:0] act;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) act = ACT_SCAN;
            else if (pick < 70) act = ACT_LOAD;
            else if (pick < 95) act = ACT_COUNT;
            else act = ACT_NONE;
            if (i == n / 2) gen_hold = 1'b1;
            queue_request(act, 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        // Phase 1: sender idles 38%, receiver stalls 61%
        gen_tx_pct = 38;
        gen_rx_pct = 61;
        queue_scans(4);                            // reset digits, point on
        queue_request(ACT_LOAD, 8'hff, 8'hff);     // largest reading, 255
        queue_scans(4);
        queue_request(ACT_LOAD, 8'h0f, 8'hf0);     // discarded bits only, reads 0
        queue_request(ACT_LOAD, 8'h90, 8'h09);     // 153
        queue_scans(4);
        queue_request(ACT_LOAD, 8'h00, 8'h00);
        queue_request(ACT_COUNT, 8'hff, 8'h00);    // point off
        queue_scans(4);
        queue_request(ACT_NONE, 8'hff, 8'hff);     // ignored action
        queue_scans(1);
        queue_random(300);

        // Phase 2: roles swapped
        gen_tx_pct = 61;
        gen_rx_pct = 38;
        gen_hold = 1'b1;
        queue_random(300);

        // Phase 3: no idling
        gen_tx_pct = 0;
        gen_rx_pct = 0;
        gen_hold = 1'b1;
        queue_random(300);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid || scans_outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (expected_scans.size() != 0) begin
            note_failure($sformatf("%0d scan results never arrived", expected_scans.size()));
        end

        $display("Covered %0d scans, %0d loads, %0d counts and %0d no-ops;",
                 n_scan, n_load, n_count, n_none);
        $display("%0d scan results checked under three idle/stall mixes, %0d mismatches.",
                 n_checked, fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/sssd_pkg.sv
design/sssd_digits.sv
design/seven_segment_reading_display.sv
design/sssd_checker.sv
tb/sv/seven_segment_reading_display_tb.sv
